// ----- hw/rtl/tlt_pkg.sv -----
`default_nettype none
package tlt_pkg;

   localparam int COLOR_BITS     = 8;
   localparam int FRAC_BITS      = 8;
   localparam int COORD_BITS     = 4;
   localparam int HALF_BITS      = COORD_BITS - 1;
   localparam int BANK_COUNT     = 8;
   localparam int BANK_ADDR_BITS = 3 * HALF_BITS;
   localparam int BANK_DEPTH     = 2 ** BANK_ADDR_BITS;
   localparam int CELLS_BITS     = 4;
   localparam int SLICE_BITS     = 12;
   localparam int PIXEL_BITS     = 9;
   localparam int PIXEL_SHIFT    = PIXEL_BITS - FRAC_BITS;
   localparam int PROD_BITS      = PIXEL_BITS + CELLS_BITS;
   localparam int GRID_BITS      = COORD_BITS + FRAC_BITS;
   localparam int MIX_BITS       = COLOR_BITS + FRAC_BITS + 1;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CELLS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLICE = 1'b1;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [CELLS_BITS-1:0] CELLS_RESET = 4'd9;
   localparam logic [SLICE_BITS-1:0] SLICE_RESET = 12'd1152;
   localparam logic [GRID_BITS-1:0]  GRID_TOP    =
      GRID_BITS'(((2 ** COORD_BITS) - 1) * (2 ** FRAC_BITS) - 1);
   localparam logic [FRAC_BITS:0]    ONE_W       = (FRAC_BITS + 1)'(2 ** FRAC_BITS);

   typedef logic [COLOR_BITS-1:0] chan_type;
   typedef chan_type [2:0] color_type;

   typedef struct packed {
      logic                 xp;
      logic                 yp;
      logic                 zp;
      logic [FRAC_BITS-1:0] wx;
      logic [FRAC_BITS-1:0] wy;
      logic [FRAC_BITS-1:0] wz;
   } samp_type;

   function automatic chan_type blend(chan_type a, chan_type b, logic [FRAC_BITS-1:0] w);
      logic [FRAC_BITS:0] wa;
      logic [MIX_BITS-1:0] sum;
      wa  = ONE_W - {1'b0, w};
      sum = MIX_BITS'(a) * MIX_BITS'(wa) + MIX_BITS'(b) * MIX_BITS'(w);
      return sum[FRAC_BITS+COLOR_BITS-1:FRAC_BITS];
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tlt_req_if.sv -----
`default_nettype none
interface tlt_req_if;
   import tlt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [COORD_BITS-1:0] lattice_x;
   logic [COORD_BITS-1:0] lattice_y;
   logic [COORD_BITS-1:0] lattice_z;
   logic [COLOR_BITS-1:0] red_in;
   logic [COLOR_BITS-1:0] green_in;
   logic [COLOR_BITS-1:0] blue_in;
   logic [PIXEL_BITS-1:0] pixel_x;
   logic [PIXEL_BITS-1:0] pixel_y;
   modport source (output valid, mode, lattice_x, lattice_y, lattice_z, red_in, green_in,
                   blue_in, pixel_x, pixel_y, input ready);
   modport sink (input valid, mode, lattice_x, lattice_y, lattice_z, red_in, green_in,
                 blue_in, pixel_x, pixel_y, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tlt_rsp_if.sv -----
`default_nettype none
interface tlt_rsp_if;
   import tlt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red_out;
   logic [COLOR_BITS-1:0] green_out;
   logic [COLOR_BITS-1:0] blue_out;
   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tlt_bank.sv -----
`default_nettype none
module tlt_bank (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [tlt_pkg::BANK_ADDR_BITS-1:0]    wr_addr,
   input  tlt_pkg::color_type                    wr_data,
   input  logic                                  rd_en,
   input  logic [tlt_pkg::BANK_ADDR_BITS-1:0]    rd_addr,
   output tlt_pkg::color_type                    rd_data
);
   import tlt_pkg::*;

   color_type mem [BANK_DEPTH];
   color_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/tlt_lattice.sv -----
`default_nettype none
module tlt_lattice (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [tlt_pkg::COORD_BITS-1:0]                wr_x,
   input  logic [tlt_pkg::COORD_BITS-1:0]                wr_y,
   input  logic [tlt_pkg::COORD_BITS-1:0]                wr_z,
   input  tlt_pkg::color_type                            wr_color,
   input  logic                                          rd_en,
   input  logic [tlt_pkg::COORD_BITS-1:0]                rd_x,
   input  logic [tlt_pkg::COORD_BITS-1:0]                rd_y,
   input  logic [tlt_pkg::COORD_BITS-1:0]                rd_z,
   output tlt_pkg::color_type [tlt_pkg::BANK_COUNT-1:0]  rd_data
);
   import tlt_pkg::*;

   logic [COORD_BITS-1:0]     x_next, y_next, z_next;
   logic [2:0]                wr_bank;
   logic [BANK_ADDR_BITS-1:0] wr_addr;

   assign x_next  = rd_x + COORD_BITS'(1);
   assign y_next  = rd_y + COORD_BITS'(1);
   assign z_next  = rd_z + COORD_BITS'(1);
   assign wr_bank = {wr_z[0], wr_y[0], wr_x[0]};
   assign wr_addr = {wr_z[COORD_BITS-1:1], wr_y[COORD_BITS-1:1], wr_x[COORD_BITS-1:1]};

   for (genvar b = 0; b < BANK_COUNT; b++) begin : g_bank
      localparam logic [2:0] BI = 3'(b);
      logic [HALF_BITS-1:0]      ax, ay, az;
      logic [BANK_ADDR_BITS-1:0] rd_addr;

      assign ax      = (rd_x[0] == BI[0]) ? rd_x[COORD_BITS-1:1] : x_next[COORD_BITS-1:1];
      assign ay      = (rd_y[0] == BI[1]) ? rd_y[COORD_BITS-1:1] : y_next[COORD_BITS-1:1];
      assign az      = (rd_z[0] == BI[2]) ? rd_z[COORD_BITS-1:1] : z_next[COORD_BITS-1:1];
      assign rd_addr = {az, ay, ax};

      tlt_bank u_bank (
         .clock   (clock),
         .wr_en   (wr_en && (wr_bank == BI)),
         .wr_addr (wr_addr),
         .wr_data (wr_color),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data[b])
      );
   end
endmodule
`default_nettype wire

// ----- hw/rtl/tlt_blend.sv -----
`default_nettype none
module tlt_blend (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          s1_valid,
   input  tlt_pkg::samp_type                             s1_samp,
   input  tlt_pkg::color_type [tlt_pkg::BANK_COUNT-1:0]  bank_data,
   output logic                                          s1_ready,
   tlt_rsp_if.source                                     rsp
);
   import tlt_pkg::*;

   color_type [BANK_COUNT-1:0] corner;
   color_type [3:0]            cx_in, cx_ff;
   color_type [1:0]            cy_in, cy_ff;
   color_type                  out_in, out_ff;
   logic [FRAC_BITS-1:0]       wy2_ff, wz2_ff, wz3_ff;
   logic                       v2_ff, v3_ff, vo_ff;
   logic                       rdy2, rdy3, rdyo;
   logic [2:0]                 par;

   assign rdyo     = !vo_ff || rsp.ready;
   assign rdy3     = !v3_ff || rdyo;
   assign rdy2     = !v2_ff || rdy3;
   assign s1_ready = !s1_valid || rdy2;
   assign par      = {s1_samp.zp, s1_samp.yp, s1_samp.xp};

   always_comb begin
      for (int c = 0; c < BANK_COUNT; c++) begin
         corner[c] = bank_data[3'(c) ^ par];
      end
      for (int j = 0; j < 4; j++) begin
         for (int ch = 0; ch < 3; ch++) begin
            cx_in[j][ch] = blend(corner[2*j][ch], corner[2*j+1][ch], s1_samp.wx);
         end
      end
      for (int k = 0; k < 2; k++) begin
         for (int ch = 0; ch < 3; ch++) begin
            cy_in[k][ch] = blend(cx_ff[2*k][ch], cx_ff[2*k+1][ch], wy2_ff);
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         out_in[ch] = blend(cy_ff[0][ch], cy_ff[1][ch], wz3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= s1_valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdyo) begin
            vo_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         cx_ff  <= cx_in;
         wy2_ff <= s1_samp.wy;
         wz2_ff <= s1_samp.wz;
      end
      if (rdy3) begin
         cy_ff  <= cy_in;
         wz3_ff <= wz2_ff;
      end
      if (rdyo) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid     = vo_ff;
   assign rsp.red_out   = out_ff[0];
   assign rsp.green_out = out_ff[1];
   assign rsp.blue_out  = out_ff[2];
endmodule
`default_nettype wire

// ----- hw/rtl/trilinear_lattice_texture.sv -----
`default_nettype none
// Trilinear lattice texture sampler. Takes one item per clock while req.ready is high:
// a write item stores one RGB point of the 16x16x16 lattice and gives no result; a sample
// item gives one blended RGB result. The lattice sits in eight parity banks of 512 entries
// (one per x, y, z parity), so the eight corners of a cell come out of one read of all eight
// banks in the same cycle; the three blend levels are registered stages behind it, each
// stage with its own hold so a stalled result does not block new transfers until the
// pipeline fills. A written point is visible to the very next sample. Entries are not
// cleared after reset and must be written before they are sampled.
module trilinear_lattice_texture (
   input  logic                                  clock,
   input  logic                                  reset,
   tlt_req_if.sink                               req,
   tlt_rsp_if.source                             rsp,
   input  logic                                  csr_we,
   input  logic [tlt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tlt_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import tlt_pkg::*;

   logic [CELLS_BITS-1:0]      cells_ff;
   logic [SLICE_BITS-1:0]      slice_ff;
   logic                       v1_ff;
   samp_type                   samp_ff, samp_in;
   logic                       ready1, accept;
   logic [PROD_BITS-1:0]       prod_x, prod_y;
   logic [GRID_BITS-1:0]       gx_raw, gy_raw, gx, gy, gz_lim, gz, limit;
   color_type                  wr_color;
   color_type [BANK_COUNT-1:0] bank_data;

   assign accept   = req.valid && ready1;
   assign req.ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CELLS_RESET;
         slice_ff <= SLICE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELLS: cells_ff <= csr_wdata[CELLS_BITS-1:0];
            CSR_SLICE: slice_ff <= csr_wdata[SLICE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prod_x = PROD_BITS'(req.pixel_x) * PROD_BITS'(cells_ff);
      prod_y = PROD_BITS'(req.pixel_y) * PROD_BITS'(cells_ff);
      gx_raw = GRID_BITS'(prod_x >> PIXEL_SHIFT);
      gy_raw = GRID_BITS'(prod_y >> PIXEL_SHIFT);
      gx     = (gx_raw > GRID_TOP) ? GRID_TOP : gx_raw;
      gy     = (gy_raw > GRID_TOP) ? GRID_TOP : gy_raw;
      limit  = {cells_ff, FRAC_BITS'(0)};
      if (slice_ff >= limit) begin
         gz_lim = (cells_ff == '0) ? '0 : limit - GRID_BITS'(1);
      end else begin
         gz_lim = slice_ff;
      end
      gz         = (gz_lim > GRID_TOP) ? GRID_TOP : gz_lim;
      samp_in.xp = gx[FRAC_BITS];
      samp_in.yp = gy[FRAC_BITS];
      samp_in.zp = gz[FRAC_BITS];
      samp_in.wx = gx[FRAC_BITS-1:0];
      samp_in.wy = gy[FRAC_BITS-1:0];
      samp_in.wz = gz[FRAC_BITS-1:0];
      wr_color   = {req.blue_in, req.green_in, req.red_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= accept && (req.mode == MODE_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         samp_ff <= samp_in;
      end
   end

   tlt_lattice u_lattice (
      .clock    (clock),
      .wr_en    (accept && (req.mode == MODE_WRITE)),
      .wr_x     (req.lattice_x),
      .wr_y     (req.lattice_y),
      .wr_z     (req.lattice_z),
      .wr_color (wr_color),
      .rd_en    (ready1),
      .rd_x     (gx[GRID_BITS-1:FRAC_BITS]),
      .rd_y     (gy[GRID_BITS-1:FRAC_BITS]),
      .rd_z     (gz[GRID_BITS-1:FRAC_BITS]),
      .rd_data  (bank_data)
   );

   tlt_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (v1_ff),
      .s1_samp   (samp_ff),
      .bank_data (bank_data),
      .s1_ready  (ready1),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req.ready) else $error("input stalled with empty read stage");
   a_sample_enters: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.mode == MODE_SAMPLE) |=> v1_ff)
      else $error("sample transfer lost");
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.mode == MODE_WRITE) |=> !v1_ff)
      else $error("write transfer entered blend pipeline");
`endif
endmodule
`default_nettype wire
